// ===== rtl/core/ctbpq_pkg.sv =====
// Shared types, codes and widths for the credit token bucket priority queue.
package ctbpq_pkg;

    localparam int SIZE_W  = 11;
    localparam int BYTES_W = 16;
    localparam int CFG_W   = 16;
    localparam int TOKEN_W = 24;
    localparam int FRAC_W  = 8;
    localparam int REQ_W   = 2;
    localparam int CHOICE_W = 2;
    localparam int CFG_ADDR_W = 2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    localparam int FIFO_DEPTH_DEF = 64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ARRIVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd2;

    // Serve codes
    localparam logic [CHOICE_W-1:0] SERVE_NONE   = 2'd0;
    localparam logic [CHOICE_W-1:0] SERVE_CREDIT = 2'd1;
    localparam logic [CHOICE_W-1:0] SERVE_DATA   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BYTE_LIMIT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUCKET_DEPTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOKENS_PER_TICK = 2'd2;

    localparam logic [CFG_W-1:0] BYTE_LIMIT_RST      = 16'd4096;
    localparam logic [CFG_W-1:0] BUCKET_DEPTH_RST    = 16'd2048;
    localparam logic [CFG_W-1:0] TOKENS_PER_TICK_RST = 16'd256;

    typedef struct packed {
        logic load;    // latch the incoming item
        logic commit;  // update state and load the result register
    } ctbpq_cmd_t;

    typedef struct packed {
        logic out_free;  // result register empty or being taken this cycle
    } ctbpq_stat_t;

endpackage

// ===== rtl/core/ctbpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ctbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ctbpq_ctrl.sv =====
// Controller: sequences one item through latch and execute.
module ctbpq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ctbpq_pkg::ctbpq_stat_t stat,
    output ctbpq_pkg::ctbpq_cmd_t  cmd
);
    import ctbpq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        cmd.load   = in_ready_reg && in_valid;
        cmd.commit = (state_reg == ST_EXEC) && stat.out_free;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while the result register is still occupied
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== rtl/core/ctbpq_dp.sv =====
// Datapath: size FIFO, byte total, token bucket, config and result register.
module ctbpq_dp #(
    parameter int FIFO_DEPTH = ctbpq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ctbpq_pkg::ctbpq_cmd_t                 cmd,
    output ctbpq_pkg::ctbpq_stat_t                stat,
    input  logic [ctbpq_pkg::REQ_W-1:0]           in_req_type,
    input  logic [ctbpq_pkg::SIZE_W-1:0]          in_credit_size,
    input  logic                                  in_data_waiting,
    input  logic                                  cfg_we,
    input  logic [ctbpq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ctbpq_pkg::CFG_W-1:0]           cfg_wdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_credit_dropped,
    output logic [ctbpq_pkg::CHOICE_W-1:0]        out_serve_choice,
    output logic [ctbpq_pkg::SIZE_W-1:0]          out_served_size,
    output logic [ctbpq_pkg::SIZE_W-1:0]          out_token_shortfall,
    output logic [ctbpq_pkg::BYTES_W-1:0]         out_credit_bytes_queued
);
    import ctbpq_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int WHOLE_W = TOKEN_W - FRAC_W;

    // latched item
    logic [REQ_W-1:0]  req_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              data_reg;

    // config
    logic [CFG_W-1:0] limit_reg, depth_reg, rate_reg;

    // queue and bucket state
    logic [AW-1:0]      head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [TOKEN_W-1:0] token_reg, token_next;

    // result register
    logic                out_valid_reg;
    logic                dropped_reg, dropped_next;
    logic [CHOICE_W-1:0] choice_reg, choice_next;
    logic [SIZE_W-1:0]   served_reg, served_next;
    logic [SIZE_W-1:0]   short_reg, short_next;
    logic [BYTES_W-1:0]  queued_reg;

    logic [SIZE_W-1:0]    head_size;
    logic                 fifo_wr;
    logic                 fifo_full, fifo_have;
    logic [BYTES_W:0]     bytes_sum;
    logic [TOKEN_W:0]     tick_level;
    logic [WHOLE_W-1:0]   whole;
    logic                 covered;

    ctbpq_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (fifo_wr),
        .wr_addr (tail_reg),
        .wr_data (size_reg),
        .rd_addr (head_reg),
        .rd_data (head_size)
    );

    always_comb
    begin
        fifo_full  = (count_reg == CW'(FIFO_DEPTH));
        fifo_have  = (count_reg != '0);
        bytes_sum  = {1'b0, bytes_reg} + (BYTES_W+1)'(size_reg);
        tick_level = {1'b0, token_reg} + (TOKEN_W+1)'(rate_reg);
        whole      = token_reg[TOKEN_W-1:FRAC_W];
        covered    = whole >= WHOLE_W'(head_size);

        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        bytes_next   = bytes_reg;
        token_next   = token_reg;
        fifo_wr      = 1'b0;
        dropped_next = 1'b0;
        choice_next  = SERVE_NONE;
        served_next  = '0;
        short_next   = '0;

        if (cmd.commit)
        begin
            unique case (req_reg)
                REQ_TICK:
                begin
                    // cap the whole part at the bucket depth, keep the fraction
                    if (tick_level[TOKEN_W:FRAC_W] > (WHOLE_W+1)'(depth_reg))
                    begin
                        token_next = {depth_reg, tick_level[FRAC_W-1:0]};
                    end
                    else
                    begin
                        token_next = tick_level[TOKEN_W-1:0];
                    end
                end
                REQ_ARRIVE:
                begin
                    if (fifo_full || (bytes_sum > (BYTES_W+1)'(limit_reg)))
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fifo_wr    = 1'b1;
                        tail_next  = (tail_reg == AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        bytes_next = bytes_sum[BYTES_W-1:0];
                    end
                end
                REQ_DEQUEUE:
                begin
                    if (fifo_have && covered)
                    begin
                        choice_next = SERVE_CREDIT;
                        served_next = head_size;
                        token_next  = token_reg - {{(WHOLE_W-SIZE_W){1'b0}}, head_size,
                                                   {FRAC_W{1'b0}}};
                        head_next   = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                        bytes_next  = (bytes_reg >= BYTES_W'(head_size)) ?
                                      bytes_reg - BYTES_W'(head_size) : '0;
                    end
                    else if (data_reg)
                    begin
                        choice_next = SERVE_DATA;
                    end
                    else if (fifo_have)
                    begin
                        // whole is below head_size here, so the low bits suffice
                        short_next = head_size - whole[SIZE_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            token_reg     <= '0;
            limit_reg     <= BYTE_LIMIT_RST;
            depth_reg     <= BUCKET_DEPTH_RST;
            rate_reg      <= TOKENS_PER_TICK_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            token_reg <= token_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_BYTE_LIMIT:      limit_reg <= cfg_wdata;
                    CFG_BUCKET_DEPTH:    depth_reg <= cfg_wdata;
                    CFG_TOKENS_PER_TICK: rate_reg  <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= in_req_type;
            size_reg <= in_credit_size;
            data_reg <= in_data_waiting;
        end
        if (cmd.commit)
        begin
            dropped_reg <= dropped_next;
            choice_reg  <= choice_next;
            served_reg  <= served_next;
            short_reg   <= short_next;
            queued_reg  <= bytes_next;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid               = out_valid_reg;
    assign out_credit_dropped      = dropped_reg;
    assign out_serve_choice        = choice_reg;
    assign out_served_size         = served_reg;
    assign out_token_shortfall     = short_reg;
    assign out_credit_bytes_queued = queued_reg;

endmodule

// ===== rtl/core/credit_token_bucket_priority_queue.sv =====
// Credit shaper top level: token bucket over a credit FIFO; a covered credit has priority over data.
//
// Input stream s_axis: one item per request. tuser carries the request kind
// (tick, credit arrival, dequeue); tdata carries the credit size and the
// data-waiting flag. Every item yields exactly one result item on m_axis:
// drop flag, serve choice, served size, token shortfall and the credit byte
// total after the item.
// An item is latched on acceptance and then executed, once the head entry of
// the size RAM (registered read) is available and the output register is free.
// The result appears on m_axis the cycle after execution, and the next item
// may be accepted in that same cycle; only one item is in flight at a time, so
// a new item is not taken before the last one has executed.
// When the receiver stalls, the finished result is held in the output
// register and one more item is accepted and latched; it waits in execute,
// with s_axis_tready low, until the output register frees.
// Reset clears the FIFO pointers, byte total and token level, and returns the
// configuration registers to their defaults; the size RAM needs no clearing.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must do so while idle, unchecked by the block.
module credit_token_bucket_priority_queue #(
    parameter int FIFO_DEPTH = ctbpq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [10:0] credit_size, [11] data_waiting, [15:12] zero
    input  logic [ctbpq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] req_type
    input  logic [ctbpq_pkg::REQ_W-1:0]           s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] credit_dropped, [2:1] serve_choice, [13:3] served_size,
    // [24:14] token_shortfall, [40:25] credit_bytes_queued, [47:41] zero
    output logic [ctbpq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic [ctbpq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ctbpq_pkg::CFG_W-1:0]           cfg_wdata
);
    import ctbpq_pkg::*;

    ctbpq_cmd_t  cmd;
    ctbpq_stat_t stat;

    logic                credit_dropped;
    logic [CHOICE_W-1:0] serve_choice;
    logic [SIZE_W-1:0]   served_size;
    logic [SIZE_W-1:0]   token_shortfall;
    logic [BYTES_W-1:0]  credit_bytes_queued;

    ctbpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctbpq_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .stat                    (stat),
        .in_req_type             (s_axis_tuser),
        .in_credit_size          (s_axis_tdata[SIZE_W-1:0]),
        .in_data_waiting         (s_axis_tdata[SIZE_W]),
        .cfg_we                  (cfg_we),
        .cfg_addr                (cfg_addr),
        .cfg_wdata               (cfg_wdata),
        .out_valid               (m_axis_tvalid),
        .out_ready               (m_axis_tready),
        .out_credit_dropped      (credit_dropped),
        .out_serve_choice        (serve_choice),
        .out_served_size         (served_size),
        .out_token_shortfall     (token_shortfall),
        .out_credit_bytes_queued (credit_bytes_queued)
    );

    assign m_axis_tdata = {7'b0, credit_bytes_queued, token_shortfall, served_size,
                           serve_choice, credit_dropped};

    // one item in flight: ready drops after every acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another is in flight");

    // a result never both drops a credit and serves something
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && credit_dropped |-> serve_choice == SERVE_NONE)
        else $error("drop and serve in one result");

    // shortfall only when nothing was served
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (token_shortfall != '0) |->
            (serve_choice == SERVE_NONE) && (served_size == '0))
        else $error("shortfall reported alongside a serve");

    // a served size is reported only for a credit serve
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (served_size != '0) |-> serve_choice == SERVE_CREDIT)
        else $error("served size without a credit serve");

endmodule

// ===== tb/tb_credit_token_bucket_priority_queue.sv =====
// Self-checking testbench for the credit token bucket priority queue.
`timescale 1ns / 100ps

module tb_credit_token_bucket_priority_queue;

    import ctbpq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [SIZE_W-1:0] size;
        logic              waiting;
    } shaper_req_t;

    typedef struct packed {
        logic                dropped;
        logic [CHOICE_W-1:0] choice;
        logic [SIZE_W-1:0]   served;
        logic [SIZE_W-1:0]   shortfall;
        logic [BYTES_W-1:0]  bytes;
    } shaper_outcome_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [10:0] credit_size, [11] data_waiting, [15:12] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] req_type
    logic [REQ_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] credit_dropped, [2:1] serve_choice, [13:3] served_size,
    // [24:14] token_shortfall, [40:25] credit_bytes_queued, [47:41] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // Shaper state as the block should hold it
    logic [SIZE_W-1:0]  credit_sizes [$];
    logic [TOKEN_W-1:0] bucket_level = '0;
    logic [BYTES_W-1:0] byte_total = '0;
    logic [CFG_W-1:0]   byte_limit = BYTE_LIMIT_RST;
    logic [CFG_W-1:0]   depth_cap = BUCKET_DEPTH_RST;
    logic [CFG_W-1:0]   fill_rate = TOKENS_PER_TICK_RST;

    shaper_req_t     request_backlog [$];
    shaper_outcome_t expected_outcomes [$];

    int items_offered = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int stall_left = 0;
    bit long_stall_done = 1'b0;

    credit_token_bucket_priority_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic shaper_outcome_t shape_request(input shaper_req_t r);
        shaper_outcome_t   res;
        logic [31:0]       lvl;
        logic [SIZE_W-1:0] head;
        logic [15:0]       whole;
        logic              have;
        res = '0;
        have = credit_sizes.size() != 0;
        head = have ? credit_sizes[0] : '0;
        whole = bucket_level[TOKEN_W-1:FRAC_W];
        case (r.kind)
            REQ_TICK:
            begin
                lvl = 32'(bucket_level) + 32'(fill_rate);
                // cap the whole part only, keep the fraction
                if (lvl[31:FRAC_W] > 24'(depth_cap))
                    lvl = {8'd0, depth_cap, lvl[FRAC_W-1:0]};
                bucket_level = lvl[TOKEN_W-1:0];
            end
            REQ_ARRIVE:
            begin
                if (credit_sizes.size() >= FIFO_DEPTH_DEF
                    || 17'(byte_total) + 17'(r.size) > 17'(byte_limit))
                    res.dropped = 1'b1;
                else
                begin
                    credit_sizes.push_back(r.size);
                    byte_total = byte_total + BYTES_W'(r.size);
                end
            end
            REQ_DEQUEUE:
            begin
                if (have && 16'(head) <= whole)
                begin
                    res.choice = SERVE_CREDIT;
                    res.served = head;
                    bucket_level = bucket_level - {5'd0, head, 8'd0};
                    void'(credit_sizes.pop_front());
                    byte_total = (byte_total >= 16'(head)) ? byte_total - 16'(head) : '0;
                end
                else if (r.waiting)
                    res.choice = SERVE_DATA;
                else if (have)
                    res.shortfall = head - whole[SIZE_W-1:0];
            end
            default: ;
        endcase
        res.bytes = byte_total;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_request(input logic [REQ_W-1:0] kind,
                                 input logic [SIZE_W-1:0] size, input logic waiting);
        shaper_req_t r;
        r.kind = kind;
        r.size = size;
        r.waiting = waiting;
        request_backlog.push_back(r);
    endtask

    // Bursts of arrivals, ticks and dequeues, with single mixed items as noise
    task automatic queue_random(input int count);
        shaper_req_t r;
        int added;
        int burst;
        int mode;
        int pick;
        added = 0;
        while (added < count)
        begin
            mode = $urandom_range(99);
            burst = (mode < 75) ? $urandom_range(1, 60) : 1;
            repeat (burst)
            begin
                r.size = SIZE_W'($urandom_range(0, 2047));
                r.waiting = 1'($urandom_range(0, 1));
                if (mode < 25)
                begin
                    r.kind = REQ_ARRIVE;
                    pick = $urandom_range(99);
                    if (pick < 60)
                        r.size = SIZE_W'($urandom_range(0, 63));
                    else if (pick < 70)
                        r.size = '0;
                    else if (pick < 75)
                        r.size = '1;
                end
                else if (mode < 45)
                    r.kind = REQ_TICK;
                else if (mode < 75)
                    r.kind = REQ_DEQUEUE;
                else if ($urandom_range(99) < 6)
                    r.kind = REQ_UNUSED;
                else
                    r.kind = REQ_W'($urandom_range(0, 2));
                request_backlog.push_back(r);
                if (r.kind != REQ_UNUSED)
                    added++;
            end
        end
    endtask

    task automatic wait_idle;
        while (request_backlog.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BYTE_LIMIT:      byte_limit = val;
            CFG_BUCKET_DEPTH:    depth_cap = val;
            CFG_TOKENS_PER_TICK: fill_rate = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] depth,
                              input logic [CFG_W-1:0] rate);
        write_reg(CFG_BYTE_LIMIT, limit);
        write_reg(CFG_BUCKET_DEPTH, depth);
        write_reg(CFG_TOKENS_PER_TICK, rate);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue, with and without data waiting
        queue_request(REQ_DEQUEUE, 11'd0, 1'b0);
        queue_request(REQ_DEQUEUE, 11'd5, 1'b1);
        queue_request(REQ_UNUSED, 11'd2047, 1'b1);
        // zero-size credit goes out with no tokens
        queue_request(REQ_ARRIVE, 11'd0, 1'b0);
        queue_request(REQ_DEQUEUE, 11'd0, 1'b0);
        queue_request(REQ_ARRIVE, 11'd2047, 1'b1);
        queue_request(REQ_DEQUEUE, 11'd0, 1'b0);
        queue_request(REQ_DEQUEUE, 11'd2047, 1'b1);
        queue_request(REQ_TICK, 11'd2047, 1'b1);
        queue_request(REQ_DEQUEUE, 11'd0, 1'b0);
        // byte limit: one over, then exactly at it
        queue_request(REQ_ARRIVE, 11'd2047, 1'b0);
        queue_request(REQ_ARRIVE, 11'd3, 1'b0);
        queue_request(REQ_ARRIVE, 11'd2, 1'b1);
        queue_request(REQ_ARRIVE, 11'd0, 1'b0);
        queue_request(REQ_UNUSED, 11'd0, 1'b0);
        queue_request(REQ_TICK, 11'd0, 1'b0);
        queue_request(REQ_DEQUEUE, 11'd1024, 1'b0);
        queue_request(REQ_DEQUEUE, 11'd0, 1'b1);
        queue_random(150);
        wait_idle();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(170);
        wait_idle();

        // limit drops below what is already queued
        set_config(16'd1000, 16'd300, 16'h0180);
        queue_random(170);
        wait_idle();

        set_config(16'd0, 16'd0, 16'd0);
        queue_random(100);
        wait_idle();

        // shallow bucket, saturates within a few ticks
        set_config(16'd20000, 16'd50, 16'h0840);
        queue_random(170);
        wait_idle();

        set_config(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 4095)),
                   CFG_W'($urandom_range(0, 65535)));
        queue_random(170);
        wait_idle();

        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Offer items from the backlog; hold each until it is taken
    always @(negedge clk)
    begin : drive_requests
        shaper_req_t r;
        logic gap;
        if (rst_n && (!s_axis_tvalid || items_accepted == items_offered))
        begin
            gap = (items_offered < 450 || items_offered >= 600) && ($urandom_range(99) < 35);
            if (request_backlog.size() != 0 && !gap)
            begin
                r = request_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(IN_DATA_W - SIZE_W - 1){1'b0}}, r.waiting, r.size};
                s_axis_tuser <= r.kind;
                items_offered++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Random back-pressure, one long hold-off to fill the block
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!long_stall_done && results_seen >= 250)
            begin
                stall_left = 120;
                long_stall_done = 1'b1;
                m_axis_tready <= 1'b0;
            end
            else if (results_seen >= 450 && results_seen < 600)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 35);
        end
    end

    always @(posedge clk)
    begin : check_and_predict
        shaper_outcome_t want;
        shaper_req_t r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                check_field("credit_dropped", 16'(want.dropped), 16'(m_axis_tdata[0]));
                check_field("serve_choice", 16'(want.choice), 16'(m_axis_tdata[2:1]));
                check_field("served_size", 16'(want.served), 16'(m_axis_tdata[13:3]));
                check_field("token_shortfall", 16'(want.shortfall), 16'(m_axis_tdata[24:14]));
                check_field("credit_bytes_queued", want.bytes, m_axis_tdata[40:25]);
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            items_accepted++;
            r.kind = s_axis_tuser;
            r.size = s_axis_tdata[SIZE_W-1:0];
            r.waiting = s_axis_tdata[SIZE_W];
            expected_outcomes.push_back(shape_request(r));
        end
    end

endmodule
